// ----- src/pps_pkg.sv -----
package pps_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int ID_W   = 8;
    localparam int ARR_W  = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W = 8;
    localparam int OUT_TIME_W = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // saturating count of slots with work left: 0, 1, or two-or-more
    localparam logic [1:0] WORK_NONE = 2'd0;
    localparam logic [1:0] WORK_ONE  = 2'd1;
    localparam logic [1:0] WORK_MANY = 2'd2;

    typedef struct packed {
        logic               op;
        logic [ID_W-1:0]    proc_id;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]       ran_id;
        logic                  idle;
        logic                  finished;
        logic [OUT_TIME_W-1:0] first_start;
        logic [OUT_TIME_W-1:0] completion;
        logic                  all_done;
    } out_item_t;

    // token that walks the slot chain, one cell per cycle
    typedef struct packed {
        logic                  live;
        logic                  pending;
        in_item_t              req;
        logic                  cand_valid;
        logic [ID_W-1:0]       cand_id;
        logic [PRIO_W-1:0]     cand_prio;
        logic [ARR_W-1:0]      cand_arr;
        logic [BURST_W-1:0]    cand_rem;
        logic [OUT_TIME_W-1:0] cand_first;
        logic [1:0]            work_cnt;
    } chain_msg_t;

endpackage

// ----- src/pps_stream_if.sv -----
interface pps_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- src/pps_cell.sv -----
module pps_cell #(
    parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
    parameter int SLOT      = 0,
    localparam int IDX_W    = $clog2(MAX_PROCS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pps_pkg::chain_msg_t      msg_in,
    input  logic [IDX_W-1:0]         idx_in,
    output pps_pkg::chain_msg_t      msg_out,
    output logic [IDX_W-1:0]         idx_out,
    input  logic                     upd_valid,
    input  logic [IDX_W-1:0]         upd_idx,
    input  logic [TIME_BITS-1:0]     now
);

    localparam int CW = (TIME_BITS > pps_pkg::ARR_W) ? TIME_BITS : pps_pkg::ARR_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT);

    logic                          used_reg, used_next;
    logic                          started_reg, started_next;
    logic [pps_pkg::ID_W-1:0]      id_reg, id_next;
    logic [pps_pkg::ARR_W-1:0]     arr_reg, arr_next;
    logic [pps_pkg::BURST_W-1:0]   rem_reg, rem_next;
    logic [pps_pkg::PRIO_W-1:0]    prio_reg, prio_next;
    logic [TIME_BITS-1:0]          start_reg, start_next;

    logic                          live_reg, live_next;
    pps_pkg::chain_msg_t           msg_reg, msg_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;

    logic           active;
    logic           ready_now;
    logic           beats;
    logic [CW-1:0]  now_ext;
    logic [CW-1:0]  arr_ext;
    logic [CW-1:0]  start_ext;
    logic [CW-1:0]  first_ext;

    assign now_ext   = CW'(now);
    assign arr_ext   = CW'(arr_reg);
    assign start_ext = CW'(start_reg);
    assign first_ext = started_reg ? start_ext : now_ext;

    assign active    = used_reg && (rem_reg != '0);
    assign ready_now = active && (arr_ext <= now_ext);
    assign beats     = ready_now &&
                       (!msg_in.cand_valid || (prio_reg < msg_in.cand_prio) ||
                        ((prio_reg == msg_in.cand_prio) && (arr_reg < msg_in.cand_arr)));

    always_comb
    begin
        used_next    = used_reg;
        started_next = started_reg;
        id_next      = id_reg;
        arr_next     = arr_reg;
        rem_next     = rem_reg;
        prio_next    = prio_reg;
        start_next   = start_reg;
        msg_next     = msg_in;
        idx_next     = idx_in;
        live_next    = msg_in.live;

        if (msg_in.live && (msg_in.req.op == pps_pkg::OP_TICK))
        begin
            if (beats)
            begin
                msg_next.cand_valid = 1'b1;
                msg_next.cand_id    = id_reg;
                msg_next.cand_prio  = prio_reg;
                msg_next.cand_arr   = arr_reg;
                msg_next.cand_rem   = rem_reg;
                msg_next.cand_first = first_ext[pps_pkg::OUT_TIME_W-1:0];
                idx_next            = MY_IDX;
            end
            if (active && (msg_in.work_cnt != pps_pkg::WORK_MANY))
            begin
                msg_next.work_cnt = msg_in.work_cnt + 2'd1;
            end
        end

        // claim the first free slot the load request passes
        if (msg_in.live && msg_in.pending && (msg_in.req.op == pps_pkg::OP_LOAD) && !used_reg)
        begin
            used_next        = 1'b1;
            started_next     = 1'b0;
            id_next          = msg_in.req.proc_id;
            arr_next         = msg_in.req.arrival;
            rem_next         = msg_in.req.burst;
            prio_next        = msg_in.req.prio;
            msg_next.pending = 1'b0;
        end

        if (upd_valid && (upd_idx == MY_IDX))
        begin
            if (!started_reg)
            begin
                started_next = 1'b1;
                start_next   = now;
            end
            rem_next = rem_reg - 1'b1;
            if (rem_reg == pps_pkg::BURST_W'(1))
            begin
                used_next    = 1'b0;
                started_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            started_reg <= 1'b0;
            live_reg    <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            started_reg <= started_next;
            live_reg    <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        arr_reg   <= arr_next;
        rem_reg   <= rem_next;
        prio_reg  <= prio_next;
        start_reg <= start_next;
        msg_reg   <= msg_next;
        idx_reg   <= idx_next;
    end

    always_comb
    begin
        msg_out      = msg_reg;
        msg_out.live = live_reg;
    end

    assign idx_out = idx_reg;

endmodule

// ----- src/preemptive_priority_scheduler.sv -----
// Channel  Modport  Payload      Role
// cmd      sink     in_item_t    load a process (op=0) or run one tick (op=1)
// result   source   out_item_t   one result per tick, none for a load
//
// Each request walks the chain of MAX_PROCS slot cells, one cell per cycle.
// A load ends when it leaves the last cell; a tick then enters the commit state,
// where it waits while the result register stays full. Reset clears slot occupancy,
// start flags, the time counter, the chain live bits and the result valid bit.
// A stalled result holds in the output register while the next request runs.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pps_stream_if.sink    cmd,
    pps_stream_if.source  result
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CW = (TIME_BITS > pps_pkg::OUT_TIME_W) ? TIME_BITS : pps_pkg::OUT_TIME_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    pps_pkg::chain_msg_t   hold_reg, hold_next;
    logic [IDX_W-1:0]      hold_idx_reg, hold_idx_next;
    pps_pkg::out_item_t    out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    pps_pkg::chain_msg_t   launch;
    pps_pkg::chain_msg_t   msg_q [MAX_PROCS];
    logic [IDX_W-1:0]      idx_q [MAX_PROCS];
    logic [MAX_PROCS-1:0]  live_vec;

    logic                  accept;
    logic                  end_live;
    logic                  commit_fire;
    logic                  upd_valid;
    logic                  fin;
    logic [TIME_BITS-1:0]  now_inc;
    logic [CW-1:0]         now_inc_ext;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        launch            = '0;
        launch.live       = accept;
        launch.pending    = (cmd.payload.op == pps_pkg::OP_LOAD);
        launch.req        = cmd.payload;
        launch.cand_valid = 1'b0;
        launch.work_cnt   = pps_pkg::WORK_NONE;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_PROCS; k++)
        begin : g_cell
            pps_cell #(
                .MAX_PROCS (MAX_PROCS),
                .TIME_BITS (TIME_BITS),
                .SLOT      (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .msg_in    ((k == 0) ? launch : msg_q[(k == 0) ? 0 : k-1]),
                .idx_in    ((k == 0) ? '0 : idx_q[(k == 0) ? 0 : k-1]),
                .msg_out   (msg_q[k]),
                .idx_out   (idx_q[k]),
                .upd_valid (upd_valid),
                .upd_idx   (hold_idx_reg),
                .now       (now_reg)
            );
            assign live_vec[k] = msg_q[k].live;
        end
    endgenerate

    assign end_live    = msg_q[MAX_PROCS-1].live;
    assign commit_fire = (state_reg == ST_COMMIT) && (!out_valid_reg || result.ready);
    assign upd_valid   = commit_fire && hold_reg.cand_valid;
    assign fin         = hold_reg.cand_valid && (hold_reg.cand_rem == pps_pkg::BURST_W'(1));
    assign now_inc     = now_reg + 1'b1;
    assign now_inc_ext = CW'(now_inc);

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        hold_next      = hold_reg;
        hold_idx_next  = hold_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (end_live)
                begin
                    hold_next     = msg_q[MAX_PROCS-1];
                    hold_idx_next = idx_q[MAX_PROCS-1];
                    state_next    = (msg_q[MAX_PROCS-1].req.op == pps_pkg::OP_TICK) ?
                                    ST_COMMIT : ST_IDLE;
                end
            end
            ST_COMMIT:
            begin
                if (commit_fire)
                begin
                    out_next.ran_id      = hold_reg.cand_valid ? hold_reg.cand_id : '0;
                    out_next.idle        = !hold_reg.cand_valid;
                    out_next.finished    = fin;
                    out_next.first_start = fin ? hold_reg.cand_first : '0;
                    out_next.completion  = fin ? now_inc_ext[pps_pkg::OUT_TIME_W-1:0] : '0;
                    // the finishing slot was the last one with work iff the count was one
                    out_next.all_done    = fin ? (hold_reg.work_cnt == pps_pkg::WORK_ONE) :
                                                 (hold_reg.work_cnt == pps_pkg::WORK_NONE);
                    out_valid_next       = 1'b1;
                    now_next             = now_inc;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        hold_idx_reg <= hold_idx_next;
        out_reg      <= out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live_vec))
        else $error("more than one request in the slot chain");

    a_end_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        end_live |-> (state_reg == ST_SWEEP))
        else $error("request left the chain outside a sweep");

    a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (live_vec == '0))
        else $error("chain busy while accepting requests");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire |=> (result.valid && (state_reg == ST_IDLE)))
        else $error("tick commit did not present a result");

endmodule

// ----- dv/tb_preemptive_priority_scheduler.sv -----
module tb_preemptive_priority_scheduler;

    localparam int NSLOT = pps_pkg::MAX_PROCS_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 2 * NSLOT + 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pps_stream_if #(.payload_t(pps_pkg::in_item_t))  cmd_if ();
    pps_stream_if #(.payload_t(pps_pkg::out_item_t)) res_if ();

    preemptive_priority_scheduler uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if.sink),
        .result (res_if.source)
    );

    always #5 clk = ~clk;

    // scheduler state as the testbench sees it
    bit                          slot_busy  [NSLOT];
    bit [pps_pkg::ID_W-1:0]       slot_pid   [NSLOT];
    bit [pps_pkg::ARR_W-1:0]      slot_arr   [NSLOT];
    bit [pps_pkg::BURST_W-1:0]    slot_left  [NSLOT];
    bit [pps_pkg::PRIO_W-1:0]     slot_pr    [NSLOT];
    bit                          slot_begun [NSLOT];
    bit [pps_pkg::OUT_TIME_W-1:0] slot_t0    [NSLOT];
    bit [15:0]                   sched_now = '0;

    pps_pkg::out_item_t pending_tick_results[$];
    int err_cnt = 0;
    int cycles = 0;
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;

    typedef struct {
        pps_pkg::in_item_t  req;
        bit                 typed;
        pps_pkg::out_item_t want;
    } dir_row_t;

    dir_row_t dir_tab[$];

    // returns -1 for a load dropped on a full table, 0 for a stored load,
    // 1 for a tick, whose result goes to o
    function automatic int schedule_request(input pps_pkg::in_item_t r,
                                            output pps_pkg::out_item_t o);
        int best;
        o = '0;
        if (r.op == pps_pkg::OP_LOAD)
        begin
            for (int k = 0; k < NSLOT; k++)
            begin
                if (!slot_busy[k])
                begin
                    slot_busy[k]  = 1'b1;
                    slot_pid[k]   = r.proc_id;
                    slot_arr[k]   = r.arrival;
                    slot_left[k]  = r.burst;
                    slot_pr[k]    = r.prio;
                    slot_begun[k] = 1'b0;
                    slot_t0[k]    = '0;
                    return 0;
                end
            end
            return -1;
        end
        best = -1;
        for (int k = 0; k < NSLOT; k++)
        begin
            if (!slot_busy[k] || slot_left[k] == 0 || slot_arr[k] > sched_now)
                continue;
            if (best < 0 || slot_pr[k] < slot_pr[best] ||
                (slot_pr[k] == slot_pr[best] && slot_arr[k] < slot_arr[best]))
                best = k;
        end
        o.idle = 1'b1;
        o.all_done = 1'b1;
        if (best >= 0)
        begin
            o.idle = 1'b0;
            o.ran_id = slot_pid[best];
            if (!slot_begun[best])
            begin
                slot_begun[best] = 1'b1;
                slot_t0[best] = sched_now;
            end
            slot_left[best] = slot_left[best] - 1'b1;
            if (slot_left[best] == 0)
            begin
                o.finished = 1'b1;
                o.first_start = slot_t0[best];
                o.completion = sched_now + 1'b1;
                slot_busy[best] = 1'b0;
                slot_begun[best] = 1'b0;
            end
        end
        sched_now = sched_now + 1'b1;
        for (int k = 0; k < NSLOT; k++)
            if (slot_busy[k] && slot_left[k] != 0)
                o.all_done = 1'b0;
        return 1;
    endfunction

    function automatic void add_load(int id, int arr, int bur, int pr);
        dir_row_t row;
        row.req.op = pps_pkg::OP_LOAD;
        row.req.proc_id = id[pps_pkg::ID_W-1:0];
        row.req.arrival = arr[pps_pkg::ARR_W-1:0];
        row.req.burst = bur[pps_pkg::BURST_W-1:0];
        row.req.prio = pr[pps_pkg::PRIO_W-1:0];
        row.typed = 1'b0;
        row.want = '0;
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    function automatic void add_tick();
        dir_row_t row;
        row.req.op = pps_pkg::OP_TICK;
        row.req.proc_id = 8'($urandom_range(255));
        row.req.arrival = 16'($urandom_range(65535));
        row.req.burst = 16'($urandom_range(65535));
        row.req.prio = 8'($urandom_range(255));
        row.typed = 1'b0;
        row.want = '0;
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    function automatic void add_tick_typed(int ran, bit idl, bit fin, int fs, int comp,
                                           bit done);
        add_tick();
        dir_tab[$].typed = 1'b1;
        dir_tab[$].want.ran_id = ran[pps_pkg::ID_W-1:0];
        dir_tab[$].want.idle = idl;
        dir_tab[$].want.finished = fin;
        dir_tab[$].want.first_start = fs[pps_pkg::OUT_TIME_W-1:0];
        dir_tab[$].want.completion = comp[pps_pkg::OUT_TIME_W-1:0];
        dir_tab[$].want.all_done = done;
    endfunction

    function automatic pps_pkg::in_item_t rand_request(int load_pct, bit wide);
        pps_pkg::in_item_t r;
        r.op = pps_pkg::OP_TICK;
        r.proc_id = 8'($urandom_range(255));
        r.arrival = 16'($urandom_range(65535));
        r.burst = 16'($urandom_range(65535));
        r.prio = 8'($urandom_range(255));
        if ($urandom_range(99) < load_pct)
        begin
            r.op = pps_pkg::OP_LOAD;
            if (!(wide && $urandom_range(99) < 30))
            begin
                if ($urandom_range(99) < 5)
                    r.arrival = 16'(sched_now - $urandom_range(40));
                else
                    r.arrival = 16'(sched_now + $urandom_range(12));
            end
            if (wide && $urandom_range(99) < 15)
                r.burst = 16'($urandom_range(1, 65535));
            else if ($urandom_range(99) < 6)
                r.burst = 16'($urandom_range(5, 200));
            else
                r.burst = 16'($urandom_range(1, 4));
            if ($urandom_range(1))
                r.prio = 8'($urandom_range(3));
            if ($urandom_range(99) < 30)
                r.proc_id = 8'($urandom_range(7));
        end
        return r;
    endfunction

    task automatic push_request(input pps_pkg::in_item_t r, input bit typed,
                                input pps_pkg::out_item_t want, output int kind);
        pps_pkg::out_item_t predicted;
        pps_pkg::out_item_t exp_item;
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.payload <= r;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        kind = schedule_request(r, predicted);
        if (kind == 1)
        begin
            exp_item = typed ? want : predicted;
            pending_tick_results.insert(pending_tick_results.size(), exp_item);
        end
        @(negedge clk);
    endtask

    task automatic run_random(int n_items, int snd_pct, int rcv_pct, bit wide);
        int done_cnt;
        int iter;
        int load_pct;
        int kind;
        snd_idle_pct = snd_pct;
        rcv_stall_pct = rcv_pct;
        done_cnt = 0;
        iter = 0;
        load_pct = 30;
        while (done_cnt < n_items)
        begin
            // vary the load mix so the table both drains and fills up
            if (iter % 50 == 0)
                case ($urandom_range(2))
                    0: load_pct = 15;
                    1: load_pct = 30;
                    default: load_pct = 50;
                endcase
            push_request(rand_request(load_pct, wide), 1'b0, '0, kind);
            if (kind >= 0)
                done_cnt++;
            iter++;
        end
    endtask

    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pps_pkg::out_item_t got;
        pps_pkg::out_item_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.payload;
            if (pending_tick_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result at cycle %0d: ran_id=%0d idle=%0b",
                             cycles, got.ran_id, got.idle);
            end
            else
            begin
                want = pending_tick_results.pop_front();
                if (got.ran_id !== want.ran_id || got.idle !== want.idle ||
                    got.finished !== want.finished || got.first_start !== want.first_start ||
                    got.completion !== want.completion || got.all_done !== want.all_done)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  expected ran_id=%0d idle=%0b fin=%0b start=%0d comp=%0d done=%0b",
                                 want.ran_id, want.idle, want.finished, want.first_start,
                                 want.completion, want.all_done);
                        $display("  actual   ran_id=%0d idle=%0b fin=%0b start=%0d comp=%0d done=%0b",
                                 got.ran_id, got.idle, got.finished, got.first_start,
                                 got.completion, got.all_done);
                    end
                end
            end
        end
    end

    initial
    begin
        int kind;
        pps_pkg::in_item_t r;
        cmd_if.valid = 1'b0;
        cmd_if.payload = '0;

        // ticks on an empty table, then a zero-burst load that never runs
        add_tick_typed(0, 1'b1, 1'b0, 0, 0, 1'b1);
        add_load(0, 0, 0, 0);
        add_tick_typed(0, 1'b1, 1'b0, 0, 0, 1'b1);
        add_load(255, 0, 1, 255);
        add_tick_typed(255, 1'b0, 1'b1, 2, 3, 1'b1);
        // a late arrival with better priority preempts a running process
        add_load(7, 3, 3, 5);
        add_load(9, 4, 1, 0);
        add_tick_typed(7, 1'b0, 1'b0, 0, 0, 1'b0);
        add_tick();
        add_tick();
        add_tick();
        // equal priority: earlier arrival wins, then lower slot; ids repeat
        add_load(20, 7, 1, 4);
        add_load(20, 6, 1, 4);
        add_load(21, 6, 1, 4);
        add_tick();
        add_tick();
        add_tick();
        // work pending but not yet arrived: idle without all_done
        add_load(200, 20, 2, 1);
        add_tick_typed(0, 1'b1, 1'b0, 0, 0, 1'b0);
        add_load(170, 0, 2, 128);
        add_tick();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            push_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want, kind);

        run_random(270, 0, 0, 1'b0);
        run_random(270, 55, 0, 1'b0);
        run_random(270, 0, 55, 1'b0);
        run_random(270, 21, 21, 1'b0);

        // far-future arrivals hold their slots and keep all_done low
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        r = '0;
        r.op = pps_pkg::OP_LOAD;
        r.proc_id = 8'd255;
        r.arrival = 16'hFFFF;
        r.burst = 16'hFFFF;
        r.prio = 8'd255;
        push_request(r, 1'b0, '0, kind);
        r.proc_id = 8'd1;
        r.arrival = 16'hFFFE;
        r.burst = 16'd2;
        r.prio = 8'd0;
        push_request(r, 1'b0, '0, kind);
        run_random(120, 21, 21, 1'b1);

        cmd_if.valid <= 1'b0;
        while (pending_tick_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0 && pending_tick_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
